// File: rtl/core/dfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants, types and helpers for the delimited frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int MSG_SIZE = 32;
  localparam int ADDR_W   = $clog2(MSG_SIZE);
  localparam int BYTE_W   = 8;
  localparam int MINL_W   = 7;
  localparam int POS_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DATA_W = 16;

  localparam logic [ADDR_W-1:0] COUNT_MAX = ADDR_W'(MSG_SIZE - 1);

  localparam logic [BYTE_W-1:0] START_RESET = 8'd91;
  localparam logic [BYTE_W-1:0] END_RESET   = 8'd93;
  localparam logic [MINL_W-1:0] MINL_RESET  = 7'd2;

  localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET   = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE = 2'd0,
    REG_END_BYTE   = 2'd1,
    REG_MIN_LENGTH = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } ctl_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [MINL_W-1:0] min_length;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic rd_en;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic emit_hit;
    logic at_end;
    logic out_free;
  } dp_stat_t;

  function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
      r = b - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/dfr_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_regs
// Configuration registers: start byte, end byte and minimum frame length.
// ----------------------------------------------------------------------------
module dfr_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dfr_pkg::BYTE_W-1:0]        cfg_data,
  output dfr_pkg::cfg_t                     cfg
);
  import dfr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= START_RESET;
      cfg.end_byte   <= END_RESET;
      cfg.min_length <= MINL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_BYTE: cfg.start_byte <= cfg_data;
        REG_END_BYTE:   cfg.end_byte   <= cfg_data;
        REG_MIN_LENGTH: cfg.min_length <= cfg_data[MINL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/dfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_ctrl
// Sequencer: takes bytes while idle, then walks the frame store for delivery.
// ----------------------------------------------------------------------------
module dfr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dfr_pkg::dp_stat_t   stat,
  output dfr_pkg::ctl_cmd_t   cmd
);
  import dfr_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && stat.emit_hit) state_next = ST_READ;
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: begin
        if (stat.out_free) state_next = stat.at_end ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_READ: cmd.rd_en = 1'b1;
      ST_LOAD: cmd.load  = stat.out_free;
      default: ;
    endcase
  end

  // Input is never taken while a frame is being delivered
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> state == ST_IDLE)
    else $error("byte taken during delivery");

  // A read is always followed by a load attempt
  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_LOAD)
    else $error("read not followed by load");

  // Leaving delivery happens only after the closing byte is loaded
  a_exit_on_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && state_next == ST_IDLE) |-> (stat.at_end && cmd.load))
    else $error("delivery ended early");

endmodule

// File: rtl/core/dfr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_datapath
// Frame store, byte counter, frame state, read index and output register.
// ----------------------------------------------------------------------------
module dfr_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dfr_pkg::cfg_t                 cfg,
  input  logic [dfr_pkg::BYTE_W-1:0]    in_byte,
  input  dfr_pkg::ctl_cmd_t             cmd,
  output dfr_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dfr_pkg::BYTE_W-1:0]    out_byte,
  output logic [dfr_pkg::POS_W-1:0]     out_pos,
  output logic                          out_last
);
  import dfr_pkg::*;

  logic [BYTE_W-1:0] frame_store [MSG_SIZE];
  logic [BYTE_W-1:0] rd_data;

  logic              frame_open, frame_open_next;
  logic [ADDR_W-1:0] stored_count, stored_count_next;
  logic [ADDR_W-1:0] run_len;
  logic [ADDR_W-1:0] rd_idx;

  logic              is_start, is_end, emit_hit;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;

  assign is_start = (in_byte == cfg.start_byte);
  assign is_end   = !is_start && (in_byte == cfg.end_byte);
  assign emit_hit = is_end && frame_open &&
                    ({{(MINL_W-ADDR_W){1'b0}}, stored_count} >= cfg.min_length);

  assign stat.emit_hit = emit_hit;
  assign stat.at_end   = (rd_idx == run_len);
  assign stat.out_free = !out_valid || out_ready;

  // Byte classification and frame bookkeeping
  always_comb begin
    frame_open_next   = frame_open;
    stored_count_next = stored_count;
    wr_en             = 1'b0;
    wr_addr           = stored_count;
    wr_data           = upcase(in_byte);
    if (cmd.take) begin
      if (is_start) begin
        frame_open_next   = 1'b1;
        stored_count_next = ADDR_W'(1);
        wr_en             = 1'b1;
        wr_addr           = '0;
        wr_data           = in_byte;
      end else if (is_end) begin
        frame_open_next   = 1'b0;
        stored_count_next = '0;
      end else if (frame_open && stored_count < COUNT_MAX) begin
        stored_count_next = stored_count + ADDR_W'(1);
        wr_en             = 1'b1;
      end else begin
        // drop the frame
        frame_open_next   = 1'b0;
        stored_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open   <= 1'b0;
      stored_count <= '0;
    end else begin
      frame_open   <= frame_open_next;
      stored_count <= stored_count_next;
    end
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) frame_store[wr_addr] <= wr_data;
    if (cmd.rd_en && !stat.at_end) rd_data <= frame_store[rd_idx];
  end

  // Delivery index and latched run length
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      run_len <= '0;
    end else if (cmd.take && emit_hit) begin
      rd_idx  <= '0;
      run_len <= stored_count;
    end else if (cmd.load) begin
      rd_idx  <= rd_idx + ADDR_W'(1);
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte <= stat.at_end ? cfg.end_byte : rd_data;
      out_pos  <= POS_W'(rd_idx);
      out_last <= stat.at_end;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= COUNT_MAX)
    else $error("stored count past buffer limit");

  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    !frame_open |-> stored_count == '0)
    else $error("closed frame holds bytes");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || out_ready))
    else $error("output register overwritten before transfer");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> rd_idx <= run_len)
    else $error("read index past run length");

endmodule

// File: rtl/core/delimited_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_frame_receiver_top
// Assembles start/end delimited frames from a byte stream and delivers them.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata[7:0] in_byte
// m_axis    out  m_axis_tvalid/tready       tdata[7:0] out_byte, [13:8] out_pos,
//                                           [15:14] zero; tlast = last
// cfg       in   cfg_valid/cfg_ready        cfg_index (0 start, 1 end, 2 min len),
//                                           cfg_data
//
// A byte that delivers nothing leaves the sequencer idle. An end byte that
// delivers a frame of N stored bytes is followed by N+1 results, each taking a
// read state and a load state, set by the single registered read port of the
// frame store. Input is held off during delivery; m_axis_tready low stalls the
// output register. Reset (synchronous) closes the frame and restores the register
// defaults; the frame store is not cleared.
// ----------------------------------------------------------------------------
module delimited_frame_receiver_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dfr_pkg::BYTE_W-1:0]        s_axis_tdata,  // [7:0] in_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [7:0] out_byte, [13:8] out_pos
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dfr_pkg::BYTE_W-1:0]        cfg_data
);
  import dfr_pkg::*;

  cfg_t              cfg;
  ctl_cmd_t          cmd;
  dp_stat_t          stat;
  logic [BYTE_W-1:0] out_byte;
  logic [POS_W-1:0]  out_pos;

  dfr_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dfr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_byte   (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (out_byte),
    .out_pos   (out_pos),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-BYTE_W-POS_W){1'b0}}, out_pos, out_byte};

endmodule
